[rtl/ffi_pkg.sv]
`timescale 1ns / 1ps

package ffi_pkg;

   // fixed field widths
   localparam int FLUX_W  = 32;
   localparam int FIELD_W = 16;
   localparam int GAIN_W  = 16;
   localparam int CPC_W   = 11;
   localparam int CSR_W   = 16;

   // gain product is Q4.29, increment is rounded back to Q.15
   localparam int FRAC_SHIFT = 14;
   localparam int PROD_W     = FIELD_W + GAIN_W + 1;
   localparam int RND_W      = PROD_W + 1;
   localparam int INC_W      = RND_W - FRAC_SHIFT;
   localparam int EST_W      = FLUX_W + 4;

   // register indexes of the configuration port
   typedef enum logic [1:0] {
      CSR_X_GAIN           = 2'd0,
      CSR_Z_GAIN           = 2'd1,
      CSR_CELLS_PER_COLUMN = 2'd2
   } csr_index_type;

   // position flags of one cell, carried with the transaction
   typedef struct packed {
      logic first_column;
      logic first_row;
   } cell_pos_type;

   // one entry of the column store
   typedef struct packed {
      logic signed [FLUX_W-1:0]  flux;
      logic signed [FIELD_W-1:0] bz;
   } column_entry_type;

endpackage

[rtl/ffi_flux_calc.sv]
`timescale 1ns / 1ps

module ffi_flux_calc (
   input  logic signed [ffi_pkg::FLUX_W-1:0]  prev_flux,
   input  logic signed [ffi_pkg::FIELD_W-1:0] prev_bx,
   input  logic signed [ffi_pkg::FLUX_W-1:0]  col_flux,
   input  logic signed [ffi_pkg::FIELD_W-1:0] col_bz,
   input  logic        [ffi_pkg::GAIN_W-1:0]  x_gain,
   input  logic        [ffi_pkg::GAIN_W-1:0]  z_gain,
   input  ffi_pkg::cell_pos_type              pos,
   output logic signed [ffi_pkg::FLUX_W-1:0]  flux
);

   localparam int PW = ffi_pkg::PROD_W;
   localparam int RW = ffi_pkg::RND_W;
   localparam int IW = ffi_pkg::INC_W;
   localparam int EW = ffi_pkg::EST_W;
   localparam int FW = ffi_pkg::FLUX_W;
   localparam int BW = ffi_pkg::FIELD_W;
   localparam int SH = ffi_pkg::FRAC_SHIFT;

   localparam logic signed [RW-1:0] ROUND_HALF = RW'(1) <<< (SH - 1);
   localparam logic signed [EW-1:0] SAT_MAX = EW'({1'b0, {(FW-1){1'b1}}});
   localparam logic signed [EW-1:0] SAT_MIN = -SAT_MAX - EW'(1);

   logic signed [PW-1:0] prod_x;
   logic signed [PW-1:0] prod_z;
   logic signed [RW-1:0] rnd_x;
   logic signed [RW-1:0] rnd_z;
   logic signed [IW-1:0] inc_x;
   logic signed [IW-1:0] inc_z;
   logic signed [EW-1:0] left_est;
   logic signed [EW-1:0] up_est;
   logic signed [EW-1:0] avg_est;

   function automatic logic signed [FW-1:0] sat_flux(input logic signed [EW-1:0] v);
      logic signed [FW-1:0] r;
      if (v > SAT_MAX) begin
         r = SAT_MAX[FW-1:0];
      end else if (v < SAT_MIN) begin
         r = SAT_MIN[FW-1:0];
      end else begin
         r = v[FW-1:0];
      end
      return r;
   endfunction

   // bz*x_gain along x, bx*z_gain along z
   assign prod_x = $signed({{(PW-BW){col_bz[BW-1]}}, col_bz})
                 * $signed({{(PW-ffi_pkg::GAIN_W){1'b0}}, x_gain});
   assign prod_z = $signed({{(PW-BW){prev_bx[BW-1]}}, prev_bx})
                 * $signed({{(PW-ffi_pkg::GAIN_W){1'b0}}, z_gain});

   // round half up, then arithmetic shift down to Q.15
   assign rnd_x = $signed({prod_x[PW-1], prod_x}) + ROUND_HALF;
   assign rnd_z = $signed({prod_z[PW-1], prod_z}) + ROUND_HALF;
   assign inc_x = rnd_x[RW-1:SH];
   assign inc_z = rnd_z[RW-1:SH];

   assign left_est = $signed({{(EW-FW){col_flux[FW-1]}}, col_flux})
                   + $signed({{(EW-IW){inc_x[IW-1]}}, inc_x});
   assign up_est   = $signed({{(EW-FW){prev_flux[FW-1]}}, prev_flux})
                   - $signed({{(EW-IW){inc_z[IW-1]}}, inc_z});
   assign avg_est  = (left_est + up_est) >>> 1;

   always_comb begin
      if (pos.first_column) begin
         flux = pos.first_row ? '0 : sat_flux(up_est);
      end else begin
         flux = pos.first_row ? sat_flux(left_est) : sat_flux(avg_est);
      end
   end

endmodule

[rtl/flux_function_integrator_unit.sv]
`timescale 1ns / 1ps

// Flux function integrator: takes bx/bz samples of a 2D grid column by column
// (z inner) and returns one saturated Q17.15 flux value per cell, in order.
// It sustains one cell per clock while the result side does not stall; a result
// passes through the cell stage and the result register before it is presented.
// The rate is set by the recurrence through the previous-flux register and by
// the column store, which takes one write and one read per cycle (the read
// is bypassed from the same-cycle write, so short columns need no extra wait).
// The column store has no reset and no clearing pass: column 0 of each grid
// fills it before its entries are used. Gains are unsigned Q2.14;
// cells_per_column is clamped to 1..MAX_COLUMN. Write configuration only while
// the block is idle.

module flux_function_integrator_unit #(
   parameter int MAX_COLUMN = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   // input channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [ffi_pkg::FIELD_W-1:0]  req_field_x,
   input  logic signed [ffi_pkg::FIELD_W-1:0]  req_field_z,
   input  logic                                req_frame_start,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [ffi_pkg::FLUX_W-1:0]   rsp_flux_value,
   // configuration port
   input  logic                                csr_write_enable,
   input  logic [1:0]                          csr_index,
   input  logic [ffi_pkg::CSR_W-1:0]           csr_write_data
);

   localparam int ROW_W = (MAX_COLUMN > 1) ? $clog2(MAX_COLUMN) : 1;
   localparam int LEN_W = $clog2(MAX_COLUMN + 1);
   localparam int CMP_W = (LEN_W > ffi_pkg::CPC_W) ? LEN_W : ffi_pkg::CPC_W;
   localparam int FW    = ffi_pkg::FLUX_W;
   localparam int BW    = ffi_pkg::FIELD_W;

   // configuration registers
   logic [ffi_pkg::GAIN_W-1:0] x_gain_ff;
   logic [ffi_pkg::GAIN_W-1:0] z_gain_ff;
   logic [ffi_pkg::CPC_W-1:0]  cpc_ff;

   // position tracking on the accept side
   logic [ROW_W-1:0] row_ff;
   logic [ROW_W-1:0] row_in;
   logic             first_col_ff;
   logic             first_col_in;

   // cell stage
   logic                     s1_valid_ff;
   logic [ROW_W-1:0]         s1_row_ff;
   ffi_pkg::cell_pos_type    s1_pos_ff;
   logic signed [BW-1:0]     s1_bx_ff;
   logic signed [BW-1:0]     s1_bz_ff;
   ffi_pkg::column_entry_type col_rd_ff;

   // recurrence state
   logic signed [FW-1:0] prev_flux_ff;
   logic signed [BW-1:0] prev_bx_ff;

   // result register
   logic                 rsp_valid_ff;
   logic signed [FW-1:0] rsp_flux_ff;

   // column store, one entry per z cell
   ffi_pkg::column_entry_type col_mem [MAX_COLUMN];

   logic                  out_free;
   logic                  advance;
   logic                  accept;
   logic [CMP_W-1:0]      cpc_wide;
   logic [LEN_W-1:0]      eff_len;
   logic [ROW_W-1:0]      acc_row;
   logic                  acc_first_col;
   logic [LEN_W-1:0]      row_plus;
   logic signed [FW-1:0]  flux;
   ffi_pkg::cell_pos_type acc_pos;

   // handshake: the cell stage moves on whenever the result register frees up
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_flux_value = rsp_flux_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         x_gain_ff <= ffi_pkg::GAIN_W'(4202);
         z_gain_ff <= ffi_pkg::GAIN_W'(2102);
         cpc_ff    <= ffi_pkg::CPC_W'(800);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            ffi_pkg::CSR_X_GAIN:           x_gain_ff <= csr_write_data;
            ffi_pkg::CSR_Z_GAIN:           z_gain_ff <= csr_write_data;
            ffi_pkg::CSR_CELLS_PER_COLUMN: cpc_ff <= csr_write_data[ffi_pkg::CPC_W-1:0];
            default: ;
         endcase
      end
   end

   // effective column length, clamped to 1..MAX_COLUMN
   assign cpc_wide = CMP_W'(cpc_ff);
   always_comb begin
      if (cpc_wide == '0) begin
         eff_len = LEN_W'(1);
      end else if (cpc_wide > CMP_W'(MAX_COLUMN)) begin
         eff_len = LEN_W'(MAX_COLUMN);
      end else begin
         eff_len = cpc_wide[LEN_W-1:0];
      end
   end

   // position of the cell being accepted and of the one after it
   always_comb begin
      acc_first_col = req_frame_start ? 1'b1 : first_col_ff;
      if (req_frame_start || (LEN_W'(row_ff) >= eff_len)) begin
         acc_row = '0;
      end else begin
         acc_row = row_ff;
      end
      acc_pos.first_column = acc_first_col;
      acc_pos.first_row    = (acc_row == '0);
      row_plus = LEN_W'(acc_row) + LEN_W'(1);
      if (row_plus >= eff_len) begin
         row_in       = '0;
         first_col_in = 1'b0;
      end else begin
         row_in       = row_plus[ROW_W-1:0];
         first_col_in = acc_first_col;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= '0;
         first_col_ff <= 1'b1;
      end else if (accept) begin
         row_ff       <= row_in;
         first_col_ff <= first_col_in;
      end
   end

   // cell stage capture
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_row_ff <= acc_row;
         s1_pos_ff <= acc_pos;
         s1_bx_ff  <= req_field_x;
         s1_bz_ff  <= req_field_z;
      end
   end

   // column store read, bypassed when the leaving cell writes the same row
   always_ff @(posedge clock) begin
      if (accept) begin
         if (advance && (s1_row_ff == acc_row)) begin
            col_rd_ff.flux <= flux;
            col_rd_ff.bz   <= s1_bz_ff;
         end else begin
            col_rd_ff <= col_mem[acc_row];
         end
      end
   end

   // column store write as the cell leaves
   always_ff @(posedge clock) begin
      if (advance) begin
         col_mem[s1_row_ff].flux <= flux;
         col_mem[s1_row_ff].bz   <= s1_bz_ff;
      end
   end

   ffi_flux_calc u_calc (
      .prev_flux (prev_flux_ff),
      .prev_bx   (prev_bx_ff),
      .col_flux  (col_rd_ff.flux),
      .col_bz    (col_rd_ff.bz),
      .x_gain    (x_gain_ff),
      .z_gain    (z_gain_ff),
      .pos       (s1_pos_ff),
      .flux      (flux)
   );

   // recurrence through the cell above
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_flux_ff <= '0;
         prev_bx_ff   <= '0;
      end else if (advance) begin
         prev_flux_ff <= flux;
         prev_bx_ff   <= s1_bx_ff;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_flux_ff <= flux;
      end
   end

   // checks
   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted transaction did not reach the cell stage");

   a_frame_start_origin: assert property (@(posedge clock) disable iff (reset)
      (accept && req_frame_start) |=>
         (s1_row_ff == '0) && s1_pos_ff.first_column && s1_pos_ff.first_row)
      else $error("frame start did not return to the grid corner");

   a_corner_is_zero: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_pos_ff.first_column && s1_pos_ff.first_row) |-> (flux == '0))
      else $error("corner cell flux is not zero");

   a_advance_to_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff && (rsp_flux_ff == $past(flux)))
      else $error("cell result lost on its way to the result register");

endmodule
